// ===== sv/dcc_pkg.sv =====
package dcc_pkg;

    localparam int CORDIC_STAGES   = 16;
    localparam int CORDIC_GAIN_INV = 652032874;
    localparam int INV_SQRT3_Q30   = 619925131;
    localparam int INV_SQRT3_Q24   = 9686330;
    localparam int EXT_BITS        = 8;
    localparam int GAIN_FRAC       = 16;

    localparam logic [7:0] CFG_PGAIN = 8'd0;
    localparam logic [7:0] CFG_IGAIN = 8'd1;
    localparam logic [7:0] CFG_FRAC  = 8'd2;

    localparam logic OP_STEP  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam logic [15:0] FRAC_RESET = 16'd62259;

    typedef struct packed {
        logic [23:0] pgain;
        logic [23:0] igain;
        logic [15:0] frac;
    } t_cfg;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [29:0] atan_turn(input logic [3:0] i);
        logic [29:0] v;
        unique case (i)
            4'd0:  v = 30'd536870912;
            4'd1:  v = 30'd316933406;
            4'd2:  v = 30'd167458907;
            4'd3:  v = 30'd85004756;
            4'd4:  v = 30'd42667331;
            4'd5:  v = 30'd21354465;
            4'd6:  v = 30'd10679838;
            4'd7:  v = 30'd5340245;
            4'd8:  v = 30'd2670163;
            4'd9:  v = 30'd1335087;
            4'd10: v = 30'd667544;
            4'd11: v = 30'd333772;
            4'd12: v = 30'd166886;
            4'd13: v = 30'd83443;
            4'd14: v = 30'd41722;
            4'd15: v = 30'd20861;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/dcc_front.sv =====
module dcc_front #(
    parameter int DW = 96
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [DW-1:0] i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [DW-1:0] o_data
);

    logic [DW-1:0] r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          push;
    logic          pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== sv/dcc_core.sv =====
module dcc_core #(
    parameter int SW = 16,
    parameter int AW = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dcc_pkg::t_cfg        i_cfg,
    input  logic                 i_item_valid,
    output logic                 o_item_ready,
    input  logic                 i_op,
    input  logic signed [SW-1:0] i_ia,
    input  logic signed [SW-1:0] i_ib,
    input  logic [AW-1:0]        i_ang,
    input  logic signed [SW-1:0] i_td,
    input  logic signed [SW-1:0] i_tq,
    input  logic [SW-2:0]        i_vbus,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [SW-1:0] o_id,
    output logic signed [SW-1:0] o_iq,
    output logic signed [SW-1:0] o_vd,
    output logic signed [SW-1:0] o_vq,
    output logic signed [SW-1:0] o_va,
    output logic signed [SW-1:0] o_vb
);
    import dcc_pkg::*;

    localparam int F  = SW - 1;
    localparam int MW = (SW + 16 > 32) ? SW + 16 : 32;
    localparam int PW = 2 * MW;
    localparam int LW = SW + 9;
    localparam int QW = SW + 8;
    localparam int CW = $clog2(QW);
    localparam int ZW = 34;
    localparam int RND_P = GAIN_FRAC - EXT_BITS;

    localparam logic signed [PW-1:0] ONE  = 1;
    localparam logic signed [PW-1:0] SMAX = (ONE <<< F) - ONE;
    localparam logic signed [PW-1:0] SMIN = -(ONE <<< F);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_CORD   = 5'd1;
    localparam logic [4:0] S_SCALE  = 5'd2;
    localparam logic [4:0] S_PK0    = 5'd3;
    localparam logic [4:0] S_PK1    = 5'd4;
    localparam logic [4:0] S_PK2    = 5'd5;
    localparam logic [4:0] S_PK3    = 5'd6;
    localparam logic [4:0] S_PK4    = 5'd7;
    localparam logic [4:0] S_VM0    = 5'd8;
    localparam logic [4:0] S_VM1    = 5'd9;
    localparam logic [4:0] S_PI_P   = 5'd10;
    localparam logic [4:0] S_PI_I   = 5'd11;
    localparam logic [4:0] S_PI_CL  = 5'd12;
    localparam logic [4:0] S_PI_OUT = 5'd13;
    localparam logic [4:0] S_SQ0    = 5'd14;
    localparam logic [4:0] S_SQ1    = 5'd15;
    localparam logic [4:0] S_SQ2    = 5'd16;
    localparam logic [4:0] S_SQRT   = 5'd17;
    localparam logic [4:0] S_IP0    = 5'd18;
    localparam logic [4:0] S_IP1    = 5'd19;
    localparam logic [4:0] S_IP2    = 5'd20;
    localparam logic [4:0] S_IP3    = 5'd21;
    localparam logic [4:0] S_IP4    = 5'd22;
    localparam logic [4:0] S_OUT    = 5'd23;

    function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v, input int n);
        return (v + (ONE <<< (n - 1))) >>> n;
    endfunction

    function automatic logic signed [SW-1:0] sat(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] t;
        if (v > SMAX) begin
            t = SMAX;
        end else if (v < SMIN) begin
            t = SMIN;
        end else begin
            t = v;
        end
        return t[SW-1:0];
    endfunction

    logic [4:0]             r_state;
    logic [CW-1:0]          r_cnt;
    logic                   r_axis;
    logic                   r_flip;
    logic signed [ZW-1:0]   r_x;
    logic signed [ZW-1:0]   r_y;
    logic signed [ZW-1:0]   r_z;
    logic signed [SW-1:0]   r_ia;
    logic signed [SW-1:0]   r_ib;
    logic signed [SW-1:0]   r_td;
    logic signed [SW-1:0]   r_tq;
    logic [SW-2:0]          r_vbus;
    logic signed [SW-1:0]   r_c;
    logic signed [SW-1:0]   r_s;
    logic signed [SW:0]     r_be;
    logic signed [PW-1:0]   r_prod;
    logic signed [PW-1:0]   r_t;
    logic signed [PW-1:0]   r_p;
    logic signed [31:0]     r_inew;
    logic signed [31:0]     r_int_d;
    logic signed [31:0]     r_int_q;
    logic signed [SW:0]     r_err_d;
    logic signed [SW:0]     r_err_q;
    logic signed [LW-1:0]   r_vmax_ext;
    logic signed [LW-1:0]   r_qlim;
    logic signed [LW-1:0]   r_vd_ext;
    logic [2*QW-1:0]        r_rad;
    logic [2*QW-1:0]        r_root;
    logic [2*QW-1:0]        r_bit;
    logic signed [SW-1:0]   r_id;
    logic signed [SW-1:0]   r_iq;
    logic signed [SW-1:0]   r_vd;
    logic signed [SW-1:0]   r_vq;
    logic signed [SW-1:0]   r_va;
    logic signed [SW-1:0]   r_vb;
    logic                   r_out_valid;

    logic signed [MW-1:0]   mul_a;
    logic signed [MW-1:0]   mul_b;
    logic signed [SW:0]     err;
    logic signed [LW-1:0]   lim;
    logic signed [PW-1:0]   limp;
    logic signed [31:0]     acc;
    logic signed [PW-1:0]   o_sum;
    logic signed [PW-1:0]   o_clip;
    logic                   hold;
    logic signed [LW-1:0]   o_ext;
    logic signed [LW-1:0]   o_abs;
    logic signed [SW-1:0]   o_trunc;
    logic signed [PW-1:0]   i_sum;
    logic signed [ZW-1:0]   xs;
    logic signed [ZW-1:0]   ys;
    logic signed [ZW-1:0]   at;
    logic signed [ZW-1:0]   xf;
    logic signed [ZW-1:0]   yf;
    logic [31:0]            u0;
    logic                   flip0;
    logic [31:0]            u1;
    logic [2*QW-1:0]        rb_sum;
    logic                   accept;
    logic                   out_load;

    assign o_item_ready = (r_state == S_IDLE);
    assign accept       = i_item_valid && o_item_ready;
    assign out_load     = (r_state == S_OUT) && (!r_out_valid || i_ready);

    assign err   = r_axis ? r_err_q : r_err_d;
    assign lim   = r_axis ? r_qlim : r_vmax_ext;
    assign limp  = PW'(lim);
    assign acc   = r_axis ? r_int_q : r_int_d;

    assign xs = r_x >>> r_cnt[3:0];
    assign ys = r_y >>> r_cnt[3:0];
    assign at = ZW'(signed'({1'b0, atan_turn(r_cnt[3:0])}));
    assign xf = r_flip ? -r_x : r_x;
    assign yf = r_flip ? -r_y : r_y;

    assign u0    = {i_ang, {(32 - AW){1'b0}}};
    assign flip0 = u0[31] ^ u0[30];
    assign u1    = {u0[31] ^ flip0, u0[30:0]};

    assign i_sum = PW'(acc) + rnd(r_prod, RND_P);
    assign rb_sum = r_root + r_bit;

    always_comb begin
        o_sum = r_p + PW'(r_inew);
        hold  = 1'b0;
        if (o_sum > limp) begin
            o_clip = limp;
            hold   = (err > 0);
        end else if (o_sum < -limp) begin
            o_clip = -limp;
            hold   = (err < 0);
        end else begin
            o_clip = o_sum;
        end
        o_ext   = o_clip[LW-1:0];
        o_abs   = o_ext[LW-1] ? -o_ext : o_ext;
        o_abs   = o_abs >>> EXT_BITS;
        o_trunc = o_ext[LW-1] ? -o_abs[SW-1:0] : o_abs[SW-1:0];
    end

    // one shared multiplier, operands chosen by sequencer step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_SCALE: begin
                mul_a = MW'(r_ia) + (MW'(r_ib) <<< 1);
                mul_b = MW'(INV_SQRT3_Q30);
            end
            S_PK0: begin
                mul_a = MW'(r_ia);
                mul_b = MW'(r_c);
            end
            S_PK1: begin
                mul_a = MW'(r_be);
                mul_b = MW'(r_s);
            end
            S_PK2: begin
                mul_a = MW'(r_be);
                mul_b = MW'(r_c);
            end
            S_PK3: begin
                mul_a = MW'(r_ia);
                mul_b = MW'(r_s);
            end
            S_PK4: begin
                mul_a = MW'({1'b0, r_vbus});
                mul_b = MW'({1'b0, i_cfg.frac});
            end
            S_VM0: begin
                mul_a = r_prod[MW-1:0];
                mul_b = MW'(INV_SQRT3_Q24);
            end
            S_PI_P: begin
                mul_a = MW'(err);
                mul_b = MW'({1'b0, i_cfg.pgain});
            end
            S_PI_I: begin
                mul_a = MW'(err);
                mul_b = MW'({1'b0, i_cfg.igain});
            end
            S_SQ0: begin
                mul_a = MW'(r_vmax_ext);
                mul_b = MW'(r_vmax_ext);
            end
            S_SQ1: begin
                mul_a = MW'(r_vd_ext);
                mul_b = MW'(r_vd_ext);
            end
            S_IP0: begin
                mul_a = MW'(r_vd);
                mul_b = MW'(r_c);
            end
            S_IP1: begin
                mul_a = MW'(r_vq);
                mul_b = MW'(r_s);
            end
            S_IP2: begin
                mul_a = MW'(r_vd);
                mul_b = MW'(r_s);
            end
            S_IP3: begin
                mul_a = MW'(r_vq);
                mul_b = MW'(r_c);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_ia   <= i_ia;
                    r_ib   <= i_ib;
                    r_td   <= i_td;
                    r_tq   <= i_tq;
                    r_vbus <= i_vbus;
                    r_x    <= ZW'(CORDIC_GAIN_INV);
                    r_y    <= '0;
                    r_z    <= ZW'(signed'(u1));
                    r_flip <= flip0;
                    if (i_op == OP_CLEAR) begin
                        r_id <= '0;
                        r_iq <= '0;
                        r_vd <= '0;
                        r_vq <= '0;
                        r_va <= '0;
                        r_vb <= '0;
                    end
                end
            end
            S_CORD: begin
                if (!r_z[ZW-1]) begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - at;
                end else begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + at;
                end
            end
            S_SCALE: begin
                r_c <= sat(rnd(PW'(xf), 30 - F));
                r_s <= sat(rnd(PW'(yf), 30 - F));
            end
            S_PK0: begin
                r_be <= (SW + 1)'(rnd(r_prod, 30));
            end
            S_PK1: begin
                r_t <= r_prod;
            end
            S_PK2: begin
                r_id <= sat(rnd(r_t + r_prod, F));
            end
            S_PK3: begin
                r_t     <= r_prod;
                r_err_d <= (SW + 1)'(r_td) - (SW + 1)'(r_id);
            end
            S_PK4: begin
                r_iq <= sat(rnd(r_t - r_prod, F));
            end
            S_VM0: begin
                r_err_q <= (SW + 1)'(r_tq) - (SW + 1)'(r_iq);
            end
            S_VM1: begin
                r_vmax_ext <= LW'((r_prod + (ONE <<< 39)) >>> 40) <<< EXT_BITS;
            end
            S_PI_I: begin
                r_p <= rnd(r_prod, RND_P);
            end
            S_PI_CL: begin
                if (i_sum > limp) begin
                    r_inew <= limp[31:0];
                end else if (i_sum < -limp) begin
                    r_inew <= -limp[31:0];
                end else begin
                    r_inew <= i_sum[31:0];
                end
            end
            S_PI_OUT: begin
                if (r_axis) begin
                    r_vq <= o_trunc;
                end else begin
                    r_vd_ext <= o_ext;
                    r_vd     <= o_trunc;
                end
            end
            S_SQ1: begin
                r_t <= r_prod;
            end
            S_SQ2: begin
                r_rad  <= (2 * QW)'(r_t - r_prod);
                r_root <= '0;
                r_bit  <= {2'b01, {(2*QW-2){1'b0}}};
            end
            S_SQRT: begin
                if (r_rad >= rb_sum) begin
                    r_rad  <= r_rad - rb_sum;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            S_IP1: begin
                r_t <= r_prod;
            end
            S_IP2: begin
                r_va <= sat(rnd(r_t - r_prod, F));
            end
            S_IP3: begin
                r_t <= r_prod;
            end
            S_IP4: begin
                r_vb <= sat(rnd(r_t + r_prod, F));
            end
            default: begin
                r_t <= r_t;
            end
        endcase
    end

    assign r_qlim = signed'({1'b0, r_root[LW-2:0]});

    // sequencer and integrators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_axis  <= 1'b0;
            r_int_d <= '0;
            r_int_q <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_cnt  <= '0;
                    r_axis <= 1'b0;
                    if (accept) begin
                        if (i_op == OP_CLEAR) begin
                            r_int_d <= '0;
                            r_int_q <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_CORD;
                        end
                    end
                end
                S_CORD: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(CORDIC_STAGES - 1)) begin
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE:  r_state <= S_PK0;
                S_PK0:    r_state <= S_PK1;
                S_PK1:    r_state <= S_PK2;
                S_PK2:    r_state <= S_PK3;
                S_PK3:    r_state <= S_PK4;
                S_PK4:    r_state <= S_VM0;
                S_VM0:    r_state <= S_VM1;
                S_VM1:    r_state <= S_PI_P;
                S_PI_P:   r_state <= S_PI_I;
                S_PI_I:   r_state <= S_PI_CL;
                S_PI_CL:  r_state <= S_PI_OUT;
                S_PI_OUT: begin
                    if (r_axis) begin
                        r_int_q <= hold ? r_int_q : r_inew;
                        r_state <= S_IP0;
                    end else begin
                        r_int_d <= hold ? r_int_d : r_inew;
                        r_state <= S_SQ0;
                    end
                end
                S_SQ0: r_state <= S_SQ1;
                S_SQ1: r_state <= S_SQ2;
                S_SQ2: begin
                    r_cnt   <= '0;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(QW - 1)) begin
                        r_axis  <= 1'b1;
                        r_state <= S_PI_P;
                    end
                end
                S_IP0: r_state <= S_IP1;
                S_IP1: r_state <= S_IP2;
                S_IP2: r_state <= S_IP3;
                S_IP3: r_state <= S_IP4;
                S_IP4: r_state <= S_OUT;
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_id <= r_id;
            o_iq <= r_iq;
            o_vd <= r_vd;
            o_vq <= r_vq;
            o_va <= r_va;
            o_vb <= r_vb;
        end
    end

    assign o_valid = r_out_valid;

    a_cord_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CORD) |-> (r_cnt < CW'(CORDIC_STAGES)))
        else $error("cordic count out of range");

    a_sqrt_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT) |-> (r_cnt < CW'(QW)))
        else $error("root count out of range");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_op == OP_CLEAR) |=> (r_int_d == 0 && r_int_q == 0))
        else $error("integrators not cleared");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_out_valid && r_state == S_IDLE))
        else $error("result transfer lost");

endmodule

// ===== sv/dq_current_controller.sv =====
// dq current controller: one control step of a field-oriented current loop per transfer.
// A step runs an iterative CORDIC for sine and cosine, a bit-serial square root for the
// q voltage limit, and steps of a single shared multiplier for Clarke, Park, the two
// PI loops and inverse Park. A clear operation skips the computation. A two-entry
// input queue keeps accepting while a step runs, until it is full, and the result
// register holds one finished result. Configuration writes take effect at
// once and are meant to be done while the block is idle.
module dq_current_controller #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int ANGLE_WIDTH  = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [7:0]                     i_cfg_addr,
    input  logic [23:0]                    i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_operation,
    input  logic signed [SAMPLE_WIDTH-1:0] i_phase_a_current,
    input  logic signed [SAMPLE_WIDTH-1:0] i_phase_b_current,
    input  logic [ANGLE_WIDTH-1:0]         i_electrical_angle,
    input  logic signed [SAMPLE_WIDTH-1:0] i_target_d_current,
    input  logic signed [SAMPLE_WIDTH-1:0] i_target_q_current,
    input  logic [SAMPLE_WIDTH-2:0]        i_bus_voltage,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_measured_d_current,
    output logic signed [SAMPLE_WIDTH-1:0] o_measured_q_current,
    output logic signed [SAMPLE_WIDTH-1:0] o_drive_d_voltage,
    output logic signed [SAMPLE_WIDTH-1:0] o_drive_q_voltage,
    output logic signed [SAMPLE_WIDTH-1:0] o_drive_alpha_voltage,
    output logic signed [SAMPLE_WIDTH-1:0] o_drive_beta_voltage
);
    import dcc_pkg::*;

    localparam int SW = SAMPLE_WIDTH;
    localparam int AW = ANGLE_WIDTH;
    localparam int DW = 5 * SW + AW;

    t_cfg          r_cfg;
    logic [DW-1:0] in_data;
    logic [DW-1:0] q_data;
    logic          q_valid;
    logic          q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pgain <= '0;
            r_cfg.igain <= '0;
            r_cfg.frac  <= FRAC_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_PGAIN: r_cfg.pgain <= i_cfg_data;
                CFG_IGAIN: r_cfg.igain <= i_cfg_data;
                CFG_FRAC:  r_cfg.frac  <= i_cfg_data[15:0];
                default:   r_cfg       <= r_cfg;
            endcase
        end
    end

    assign in_data = {i_operation, i_phase_a_current, i_phase_b_current, i_electrical_angle,
                      i_target_d_current, i_target_q_current, i_bus_voltage};

    dcc_front #(
        .DW(DW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (in_data),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_data)
    );

    dcc_core #(
        .SW(SW),
        .AW(AW)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item_valid (q_valid),
        .o_item_ready (q_ready),
        .i_op         (q_data[DW-1]),
        .i_ia         (q_data[DW-2 -: SW]),
        .i_ib         (q_data[DW-2-SW -: SW]),
        .i_ang        (q_data[DW-2-2*SW -: AW]),
        .i_td         (q_data[DW-2-2*SW-AW -: SW]),
        .i_tq         (q_data[DW-2-3*SW-AW -: SW]),
        .i_vbus       (q_data[SW-2:0]),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_id         (o_measured_d_current),
        .o_iq         (o_measured_q_current),
        .o_vd         (o_drive_d_voltage),
        .o_vq         (o_drive_q_voltage),
        .o_va         (o_drive_alpha_voltage),
        .o_vb         (o_drive_beta_voltage)
    );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import dcc_pkg::*;

    localparam int SW = 16;
    localparam int FB = SW - 1;
    localparam longint SMAX = (64'sd1 <<< FB) - 1;
    localparam longint SMIN = -(64'sd1 <<< FB);

    typedef struct packed {
        logic [SW-1:0] id;
        logic [SW-1:0] iq;
        logic [SW-1:0] vd;
        logic [SW-1:0] vq;
        logic [SW-1:0] va;
        logic [SW-1:0] vb;
    } t_res;

    typedef struct packed {
        logic          op;
        logic [SW-1:0] ia;
        logic [SW-1:0] ib;
        logic [15:0]   ang;
        logic [SW-1:0] td;
        logic [SW-1:0] tq;
        logic [SW-2:0] vbus;
    } t_sample;

    // ---------------- control law predictor and scoreboard ----------------
    class foc_scoreboard;
        longint unsigned pgain, igain, frac;
        longint integ_d, integ_q;
        t_res pending[$];
        int errors, checked;

        function new();
            pgain = 0; igain = 0; frac = FRAC_RESET;
            integ_d = 0; integ_q = 0; errors = 0; checked = 0;
        endfunction

        function longint asr(longint v, int n);
            return v >>> n;
        endfunction

        function longint rnd(longint v, int n);
            return (v + (64'sd1 <<< (n - 1))) >>> n;
        endfunction

        function longint sat(longint v);
            if (v > SMAX) return SMAX;
            if (v < SMIN) return SMIN;
            return v;
        endfunction

        function void sincos(logic [15:0] ang, output longint s, output longint c);
            logic [31:0] u;
            logic [1:0] quad;
            bit flip;
            longint x, y, z, nx;
            u = {ang, 16'h0};
            quad = u[31:30];
            flip = (quad == 2'd1 || quad == 2'd2);
            x = CORDIC_GAIN_INV; y = 0;
            if (flip) u = u + 32'h8000_0000;
            z = longint'(signed'(u));
            for (int i = 0; i < CORDIC_STAGES; i++) begin
                if (z >= 0) begin
                    nx = x - asr(y, i); y = y + asr(x, i); z -= atan_turn(4'(i));
                end else begin
                    nx = x + asr(y, i); y = y - asr(x, i); z += atan_turn(4'(i));
                end
                x = nx;
            end
            if (flip) begin
                x = -x; y = -y;
            end
            c = sat(rnd(x, 30 - FB));
            s = sat(rnd(y, 30 - FB));
        endfunction

        function longint unsigned isqrt(longint unsigned v);
            longint unsigned r, b;
            r = 0; b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b; r = (r >> 1) + b;
                end else r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        function longint pi_law(ref longint acc, input longint err, input longint lim);
            longint p, inew, o;
            p = rnd(err * longint'(pgain), GAIN_FRAC - EXT_BITS);
            inew = acc + rnd(err * longint'(igain), GAIN_FRAC - EXT_BITS);
            if (inew > lim) inew = lim;
            if (inew < -lim) inew = -lim;
            o = p + inew;
            if (o > lim) begin
                o = lim;
                if (err > 0) inew = acc;
            end else if (o < -lim) begin
                o = -lim;
                if (err < 0) inew = acc;
            end
            acc = inew;
            return o;
        endfunction

        function longint trunc_ext(longint v);
            return v >= 0 ? (v >>> EXT_BITS) : -((-v) >>> EXT_BITS);
        endfunction

        function void set_reg(logic [7:0] idx, logic [23:0] val);
            if (idx == CFG_PGAIN) pgain = val;
            else if (idx == CFG_IGAIN) igain = val;
            else if (idx == CFG_FRAC) frac = val[15:0];
        endfunction

        function void note_sample(t_sample t);
            longint ia, ib, s, c, al, be, id, iq, vmax, vmx, vde, vqe, ql, vd, vq, va, vb;
            t_res r;
            if (t.op == OP_CLEAR) begin
                integ_d = 0; integ_q = 0;
                pending.push_back('0);
                return;
            end
            ia = longint'(signed'(t.ia));
            ib = longint'(signed'(t.ib));
            sincos(t.ang, s, c);
            al = ia;
            be = rnd((ia + 2 * ib) * INV_SQRT3_Q30, 30);
            id = sat(rnd(al * c + be * s, FB));
            iq = sat(rnd(be * c - al * s, FB));
            vmax = longint'((longint'(t.vbus) * frac * INV_SQRT3_Q24 + (64'd1 << 39)) >> 40);
            vmx = vmax <<< EXT_BITS;
            vde = pi_law(integ_d, longint'(signed'(t.td)) - id, vmx);
            ql = longint'(isqrt(longint'(vmx * vmx - vde * vde)));
            vqe = pi_law(integ_q, longint'(signed'(t.tq)) - iq, ql);
            vd = trunc_ext(vde);
            vq = trunc_ext(vqe);
            va = sat(rnd(vd * c - vq * s, FB));
            vb = sat(rnd(vd * s + vq * c, FB));
            r.id = id[SW-1:0];
            r.iq = iq[SW-1:0];
            r.vd = vd[SW-1:0];
            r.vq = vq[SW-1:0];
            r.va = va[SW-1:0];
            r.vb = vb[SW-1:0];
            pending.push_back(r);
        endfunction

        function void check_result(t_res got);
            t_res exp;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
                return;
            end
            exp = pending.pop_front();
            if (got !== exp) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch #%0d: exp id %h iq %h vd %h vq %h va %h vb %h",
                        checked, exp.id, exp.iq, exp.vd, exp.vq, exp.va, exp.vb,
                        "\n             got id %h iq %h vd %h vq %h va %h vb %h",
                        got.id, got.iq, got.vd, got.vq, got.va, got.vb);
            end
        endfunction
    endclass

    logic i_clk = 0, i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [7:0] i_cfg_addr = '0;
    logic [23:0] i_cfg_data = '0;
    logic i_valid = 0, i_ready = 0;
    t_sample drv = '0;
    logic o_ready, o_valid;
    logic signed [SW-1:0] o_id, o_iq, o_vd, o_vq, o_va, o_vb;

    foc_scoreboard sb = new();
    int n_sent = 0, n_clear = 0, n_sat = 0;
    bit stall_long = 0, stall_go = 0, quiet = 0;

    always #5 i_clk = ~i_clk;

    dq_current_controller i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_operation(drv.op), .i_phase_a_current(drv.ia), .i_phase_b_current(drv.ib),
        .i_electrical_angle(drv.ang), .i_target_d_current(drv.td),
        .i_target_q_current(drv.tq), .i_bus_voltage(drv.vbus),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_measured_d_current(o_id), .o_measured_q_current(o_iq),
        .o_drive_d_voltage(o_vd), .o_drive_q_voltage(o_vq),
        .o_drive_alpha_voltage(o_va), .o_drive_beta_voltage(o_vb)
    );

    // result side
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_result({o_id, o_iq, o_vd, o_vq, o_va, o_vb});
            if (o_vd == 0 && o_vq == 0) n_sat++;
        end
    end

    always @(negedge i_clk) begin
        if (stall_long) i_ready <= 0;
        else if (quiet) i_ready <= 1;
        else i_ready <= ($urandom_range(99) >= 14);
    end

    task automatic send(t_sample t);
        @(negedge i_clk);
        while (!quiet && $urandom_range(99) < 14) @(negedge i_clk);
        drv <= t;
        i_valid <= 1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_sample(t);
        n_sent++;
        if (t.op == OP_CLEAR) n_clear++;
        @(negedge i_clk);
        i_valid <= 0;
    endtask

    task automatic write_reg(logic [7:0] idx, logic [23:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1; i_cfg_addr <= idx; i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 0;
        sb.set_reg(idx, val);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    function automatic t_sample rand_sample(bit allow_clear);
        t_sample t;
        t.op = allow_clear && ($urandom_range(99) < 5) ? OP_CLEAR : OP_STEP;
        t.ia = SW'($urandom); t.ib = SW'($urandom); t.ang = 16'($urandom);
        t.td = SW'($urandom); t.tq = SW'($urandom);
        case ($urandom_range(3))
            0: t.vbus = '1;
            1: t.vbus = (SW - 1)'($urandom_range(16));
            default: t.vbus = (SW - 1)'($urandom);
        endcase
        if ($urandom_range(3) == 0) begin
            t.ia = $signed(t.ia) >>> 3; t.ib = $signed(t.ib) >>> 3;
        end
        return t;
    endfunction

    task automatic directed();
        logic [15:0] xs[6] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h4000, 16'hc000};
        logic [15:0] angs[6] = '{16'h0000, 16'h4000, 16'h8000, 16'hc000, 16'hffff, 16'h2000};
        t_sample t;
        for (int k = 0; k < 6; k++) begin
            t.op = OP_STEP; t.ia = xs[k]; t.ib = xs[5 - k]; t.ang = angs[k];
            t.td = xs[(k + 1) % 6]; t.tq = xs[(k + 3) % 6];
            t.vbus = (k == 2) ? '0 : (k == 3 ? 15'd1 : '1);
            send(t);
        end
        t = '0; t.op = OP_CLEAR; t.ia = 16'h7fff; send(t);
        t = '0; t.td = 16'h7fff; t.tq = 16'h8000; t.vbus = '1;
        repeat (4) send(t);
        t.op = OP_CLEAR; send(t);
        t.op = OP_STEP; t.td = 16'h8000; t.tq = 16'h7fff; send(t);
    endtask

    initial begin
        logic [23:0] pg[5] = '{24'd0, 24'hffffff, 24'h010000, 24'h004000, 24'h000800};
        logic [23:0] ig[5] = '{24'd0, 24'hffffff, 24'h000400, 24'h002000, 24'h000100};
        logic [15:0] fr[5] = '{16'd0, 16'hffff, 16'd62259, 16'd32768, 16'd62259};
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        directed();
        drain();
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(CFG_PGAIN, pg[ph]);
            write_reg(CFG_IGAIN, ig[ph]);
            write_reg(CFG_FRAC, fr[ph]);
            quiet = (ph == 2);
            for (int k = 0; k < 390; k++) begin
                if (ph == 3 && k == 20) stall_go = 1;
                send(rand_sample(1));
            end
            quiet = 0;
            drain();
        end
        $display("sent %0d samples (%0d clears) over 5 gain and circle settings;", n_sent,
            n_clear);
        $display("%0d results with zero drive voltage, long receiver stall exercised",
            n_sat);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("** dq_current_controller: PASSED **");
        end else begin
            $display("%0d mismatches, %0d left over", sb.errors, sb.pending.size());
            $display("** dq_current_controller: FAILED **");
        end
        $finish;
    end

    // long receiver hold-off so the input queue fills
    initial begin
        wait (stall_go);
        stall_long = 1;
        repeat (600) @(posedge i_clk);
        stall_long = 0;
    end

    initial begin
        #20ms;
        $display("timeout");
        $display("** dq_current_controller: FAILED **");
        $finish;
    end
endmodule
